[design/matrix4x4_float_multiply_assert.svh]
// Assertion macros for the 4x4 matrix multiply block.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MATRIX4X4_FLOAT_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_FLOAT_MULTIPLY_ASSERT_SVH

// Check a consequence in the cycle after the trigger.
`define MMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmf assertion failed");

// Check a consequence in the same cycle as the trigger.
`define MMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmf assertion failed");

`endif

[design/mmf_pkg.sv]
`timescale 1ns / 1ps
package mmf_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MUL  = 1'b1
    } t_opcode;

    typedef logic signed [9:0] t_exp;

    typedef struct packed {
        t_exp        e;
        logic [30:0] sig;
    } t_rnd;

    localparam int MUL_LAT  = 4;
    localparam int ADD_LAT  = 5;
    localparam int PIPE_LAT = 1 + MUL_LAT + 3 * ADD_LAT;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [30:0] PINF = 31'h7F80_0000;

    // Leading zeros of a 31-bit word, counted down from bit 30.
    function automatic logic [4:0] lzc31(input logic [30:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                lz = 5'(30 - i);
            end
        end
        return lz;
    endfunction

    // Right shift with the shifted-out bits folded into bit 0.
    function automatic logic [30:0] jam31(input logic [30:0] v, input logic [4:0] n);
        logic [30:0] mask;
        mask = ~(31'h7FFF_FFFF << n);
        return (v >> n) | {30'd0, |(v & mask)};
    endfunction

    // Denormalize a significand whose exponent fell to zero or below.
    function automatic t_rnd rp_shift(input t_exp e, input logic [30:0] sig);
        t_rnd r;
        t_exp n;
        logic [4:0] sh;
        n = t_exp'(1) - e;
        sh = (n > t_exp'(31)) ? 5'd31 : n[4:0];
        if (e <= t_exp'(0)) begin
            r.e = t_exp'(0);
            r.sig = jam31(sig, sh);
        end else begin
            r.e = e;
            r.sig = sig;
        end
        return r;
    endfunction

    // Round to nearest even and pack; sig has 7 extra low bits.
    function automatic logic [31:0] rp_round(input logic s, input t_exp e,
                                             input logic [30:0] sig);
        logic [31:0] sum;
        logic [24:0] m;
        logic [31:0] bits;
        sum = {1'b0, sig} + 32'd64;
        m = sum[31:7];
        if (sig[6:0] == 7'h40) begin
            m[0] = 1'b0;
        end
        if (e == t_exp'(0)) begin
            bits = {7'd0, m};
        end else begin
            bits = {1'b0, e[7:0], 23'd0} + {7'd0, m} - 32'h0080_0000;
        end
        if (bits >= {1'b0, PINF}) begin
            bits = {1'b0, PINF};
        end
        if (e >= t_exp'(255)) begin
            bits = {1'b0, PINF};
        end
        return {s, bits[30:0]};
    endfunction

endpackage

[design/mmf_fmul.sv]
`timescale 1ns / 1ps
module mmf_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    logic        n1_ovr;
    logic [31:0] n1_val;
    logic [23:0] n1_ma, n1_mb;
    mmf_pkg::t_exp n1_ea, n1_eb;
    logic [4:0]  n1_lza, n1_lzb;
    logic        n1_s;

    logic        r1_ovr, r1_s;
    logic [31:0] r1_val;
    logic [23:0] r1_ma, r1_mb;
    mmf_pkg::t_exp r1_e;

    logic        r2_ovr, r2_s;
    logic [31:0] r2_val;
    logic [47:0] r2_p;
    mmf_pkg::t_exp r2_e;

    logic        r3_ovr, r3_s;
    logic [31:0] r3_val;
    mmf_pkg::t_rnd r3_rnd;
    mmf_pkg::t_rnd n3_rnd;
    mmf_pkg::t_exp n3_e;
    logic [30:0] n3_sig;

    logic [31:0] r4_res;

    // Unpack, classify, normalize subnormal significands.
    always_comb begin
        n1_s = i_a[31] ^ i_b[31];
        n1_lza = mmf_pkg::lzc31({1'b0, i_a[22:0], 7'd0});
        n1_lzb = mmf_pkg::lzc31({1'b0, i_b[22:0], 7'd0});
        if (i_a[30:23] == 8'd0) begin
            n1_ea = mmf_pkg::t_exp'(1) - mmf_pkg::t_exp'({5'd0, n1_lza});
            n1_ma = {1'b0, i_a[22:0]} << n1_lza;
        end else begin
            n1_ea = mmf_pkg::t_exp'({2'd0, i_a[30:23]});
            n1_ma = {1'b1, i_a[22:0]};
        end
        if (i_b[30:23] == 8'd0) begin
            n1_eb = mmf_pkg::t_exp'(1) - mmf_pkg::t_exp'({5'd0, n1_lzb});
            n1_mb = {1'b0, i_b[22:0]} << n1_lzb;
        end else begin
            n1_eb = mmf_pkg::t_exp'({2'd0, i_b[30:23]});
            n1_mb = {1'b1, i_b[22:0]};
        end
        n1_ovr = 1'b1;
        if (i_a[30:0] > mmf_pkg::PINF || i_b[30:0] > mmf_pkg::PINF) begin
            n1_val = mmf_pkg::QNAN;
        end else if (i_a[30:0] == mmf_pkg::PINF || i_b[30:0] == mmf_pkg::PINF) begin
            if (i_a[30:0] == 31'd0 || i_b[30:0] == 31'd0) begin
                n1_val = mmf_pkg::QNAN;
            end else begin
                n1_val = {n1_s, mmf_pkg::PINF};
            end
        end else if (i_a[30:0] == 31'd0 || i_b[30:0] == 31'd0) begin
            n1_val = {n1_s, 31'd0};
        end else begin
            n1_ovr = 1'b0;
            n1_val = {n1_s, 31'd0};
        end
    end

    always_comb begin
        if (r2_p[47]) begin
            n3_sig = r2_p[47:17] | {30'd0, |r2_p[16:0]};
            n3_e = r2_e + mmf_pkg::t_exp'(1);
        end else begin
            n3_sig = r2_p[46:16] | {30'd0, |r2_p[15:0]};
            n3_e = r2_e;
        end
        n3_rnd = mmf_pkg::rp_shift(n3_e, n3_sig);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ovr <= n1_ovr;
            r1_val <= n1_val;
            r1_s   <= n1_s;
            r1_ma  <= n1_ma;
            r1_mb  <= n1_mb;
            r1_e   <= n1_ea + n1_eb - mmf_pkg::t_exp'(127);

            r2_ovr <= r1_ovr;
            r2_val <= r1_val;
            r2_s   <= r1_s;
            r2_e   <= r1_e;
            r2_p   <= r1_ma * r1_mb;

            r3_ovr <= r2_ovr;
            r3_val <= r2_val;
            r3_s   <= r2_s;
            r3_rnd <= n3_rnd;

            r4_res <= r3_ovr ? r3_val : mmf_pkg::rp_round(r3_s, r3_rnd.e, r3_rnd.sig);
        end
    end

    assign o_p = r4_res;

endmodule

[design/mmf_fadd.sv]
`timescale 1ns / 1ps
module mmf_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    logic        n1_swap, n1_ovr;
    logic [31:0] n1_x, n1_y, n1_val;
    logic [7:0]  n1_ex, n1_ey;

    logic        r1_ovr, r1_s, r1_sub;
    logic [31:0] r1_val;
    logic [23:0] r1_mx, r1_my;
    logic [7:0]  r1_e, r1_d;

    logic        r2_ovr, r2_s, r2_sub;
    logic [31:0] r2_val;
    logic [30:0] r2_ma, r2_mb;
    logic [7:0]  r2_e;

    logic        n3_ovr;
    logic [31:0] n3_val, n3_sum;
    logic [30:0] n3_r;
    logic [8:0]  n3_e;

    logic        r3_ovr, r3_s, r3_sub;
    logic [31:0] r3_val;
    logic [30:0] r3_r;
    logic [8:0]  r3_e;

    logic [4:0]  n4_lz;
    logic [8:0]  n4_em1, n4_sh;

    logic        r4_ovr, r4_s;
    logic [31:0] r4_val;
    logic [30:0] r4_r;
    logic [8:0]  r4_e;

    logic [31:0] r5_res;

    // Order by magnitude and catch the special operands.
    always_comb begin
        n1_swap = i_a[30:0] < i_b[30:0];
        n1_x = n1_swap ? i_b : i_a;
        n1_y = n1_swap ? i_a : i_b;
        n1_ex = (n1_x[30:23] == 8'd0) ? 8'd1 : n1_x[30:23];
        n1_ey = (n1_y[30:23] == 8'd0) ? 8'd1 : n1_y[30:23];
        n1_ovr = 1'b1;
        if (i_a[30:0] > mmf_pkg::PINF || i_b[30:0] > mmf_pkg::PINF) begin
            n1_val = mmf_pkg::QNAN;
        end else if (i_a[30:0] == mmf_pkg::PINF) begin
            if (i_b[30:0] == mmf_pkg::PINF && i_a[31] != i_b[31]) begin
                n1_val = mmf_pkg::QNAN;
            end else begin
                n1_val = i_a;
            end
        end else if (i_b[30:0] == mmf_pkg::PINF) begin
            n1_val = i_b;
        end else if (i_a[30:0] == 31'd0 && i_b[30:0] == 31'd0) begin
            n1_val = {i_a[31] & i_b[31], 31'd0};
        end else if (i_a[30:0] == 31'd0) begin
            n1_val = i_b;
        end else if (i_b[30:0] == 31'd0) begin
            n1_val = i_a;
        end else begin
            n1_ovr = 1'b0;
            n1_val = i_a;
        end
    end

    always_comb begin
        n3_ovr = r2_ovr;
        n3_val = r2_val;
        n3_e = {1'b0, r2_e};
        n3_sum = {1'b0, r2_ma} + {1'b0, r2_mb};
        if (!r2_sub) begin
            if (n3_sum[31]) begin
                n3_r = n3_sum[31:1] | {30'd0, n3_sum[0]};
                n3_e = {1'b0, r2_e} + 9'd1;
            end else begin
                n3_r = n3_sum[30:0];
            end
        end else begin
            n3_r = r2_ma - r2_mb;
            // Exact cancellation gives +0.
            if (n3_r == 31'd0 && !r2_ovr) begin
                n3_ovr = 1'b1;
                n3_val = 32'd0;
            end
        end
    end

    // Renormalize after subtraction, but not below the smallest exponent.
    always_comb begin
        n4_lz = mmf_pkg::lzc31(r3_r);
        n4_em1 = r3_e - 9'd1;
        n4_sh = ({4'd0, n4_lz} < n4_em1) ? {4'd0, n4_lz} : n4_em1;
        if (!r3_sub) begin
            n4_sh = 9'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ovr <= n1_ovr;
            r1_val <= n1_val;
            r1_s   <= n1_x[31];
            r1_sub <= n1_x[31] ^ n1_y[31];
            r1_mx  <= {n1_x[30:23] != 8'd0, n1_x[22:0]};
            r1_my  <= {n1_y[30:23] != 8'd0, n1_y[22:0]};
            r1_e   <= n1_ex;
            r1_d   <= n1_ex - n1_ey;

            r2_ovr <= r1_ovr;
            r2_val <= r1_val;
            r2_s   <= r1_s;
            r2_sub <= r1_sub;
            r2_e   <= r1_e;
            r2_ma  <= {r1_mx, 7'd0};
            r2_mb  <= mmf_pkg::jam31({r1_my, 7'd0},
                                     (r1_d > 8'd31) ? 5'd31 : r1_d[4:0]);

            r3_ovr <= n3_ovr;
            r3_val <= n3_val;
            r3_s   <= r2_s;
            r3_sub <= r2_sub;
            r3_r   <= n3_r;
            r3_e   <= n3_e;

            r4_ovr <= r3_ovr;
            r4_val <= r3_val;
            r4_s   <= r3_s;
            r4_r   <= r3_r << n4_sh;
            r4_e   <= r3_e - n4_sh;

            r5_res <= r4_ovr ? r4_val
                    : mmf_pkg::rp_round(r4_s, mmf_pkg::t_exp'({1'b0, r4_e}), r4_r);
        end
    end

    assign o_s = r5_res;

endmodule

[design/mmf_column.sv]
`timescale 1ns / 1ps
module mmf_column (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [3:0][31:0] i_a,
    input  logic [3:0][31:0] i_b,
    output logic [31:0]      o_c
);

    logic [3:0][31:0] w_p;
    logic [31:0]      w_s1, w_s2, w_s3;
    logic [31:0]      r_p2_dly [mmf_pkg::ADD_LAT];
    logic [31:0]      r_p3_dly [2 * mmf_pkg::ADD_LAT];

    for (genvar i = 0; i < 4; i++) begin : g_mul
        mmf_fmul u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (i_a[i]),
            .i_b   (i_b[i]),
            .o_p   (w_p[i])
        );
    end

    // Hold the later products until the running sum catches up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2_dly[0] <= w_p[2];
            for (int k = 1; k < mmf_pkg::ADD_LAT; k++) begin
                r_p2_dly[k] <= r_p2_dly[k-1];
            end
            r_p3_dly[0] <= w_p[3];
            for (int k = 1; k < 2 * mmf_pkg::ADD_LAT; k++) begin
                r_p3_dly[k] <= r_p3_dly[k-1];
            end
        end
    end

    mmf_fadd u_add1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_p[0]),
        .i_b   (w_p[1]),
        .o_s   (w_s1)
    );

    mmf_fadd u_add2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_s1),
        .i_b   (r_p2_dly[mmf_pkg::ADD_LAT-1]),
        .o_s   (w_s2)
    );

    mmf_fadd u_add3 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_s2),
        .i_b   (r_p3_dly[2*mmf_pkg::ADD_LAT-1]),
        .o_s   (w_s3)
    );

    assign o_c = w_s3;

endmodule

[design/matrix4x4_float_multiply.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: opcode; tdata: row, four elements
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: row, four product elements
//
// One item is taken per cycle while the output is not stalled, loads and multiplies
// alike. A product row passes one input stage, a 4-stage multiplier and three
// 5-stage adders in series per column.
// A load writes its row of B at the accepting edge; a multiply in the next cycle sees it.
// Reset clears the valid bits only; B is undefined until loaded.
// A stall at the output freezes the whole pipeline and drops s_axis_tready.
module matrix4x4_float_multiply (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // row_index, elem0, elem1, elem2, elem3, zero pad
    input  logic         s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // out_row, out_c0, out_c1, out_c2, out_c3, zero pad
);

    `include "matrix4x4_float_multiply_assert.svh"

    localparam int LAST = mmf_pkg::PIPE_LAT - 1;

    logic                     w_en, w_acc;
    logic [mmf_pkg::PIPE_LAT-1:0] r_vld;
    logic [1:0]               r_row [mmf_pkg::PIPE_LAT];
    logic [3:0][31:0]         r_a;
    logic [31:0]              r_bmat [16];
    logic [3:0][31:0]         w_c;

    assign w_en = !r_vld[LAST] || m_axis_tready;
    assign w_acc = s_axis_tvalid && w_en;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], w_acc && (s_axis_tuser == mmf_pkg::OP_MUL)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_row[0] <= s_axis_tdata[1:0];
            for (int k = 1; k < mmf_pkg::PIPE_LAT; k++) begin
                r_row[k] <= r_row[k-1];
            end
            r_a <= s_axis_tdata[129:2];
        end
        if (w_acc && s_axis_tuser == mmf_pkg::OP_LOAD) begin
            for (int j = 0; j < 4; j++) begin
                r_bmat[{s_axis_tdata[1:0], 2'(j)}] <= s_axis_tdata[2+32*j +: 32];
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_col
        mmf_column u_col (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r_a),
            .i_b   ({r_bmat[12+j], r_bmat[8+j], r_bmat[4+j], r_bmat[j]}),
            .o_c   (w_c[j])
        );
    end

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata = {6'd0, w_c, r_row[LAST]};

    `MMF_ASSERT_NEXT(a_load_no_result,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == mmf_pkg::OP_LOAD, !r_vld[0])
    `MMF_ASSERT_NEXT(a_mul_enters,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == mmf_pkg::OP_MUL,
        r_vld[0] && r_row[0] == $past(s_axis_tdata[1:0]))
    `MMF_ASSERT_NEXT(a_stall_freezes, !w_en, $stable(r_vld))
    `MMF_ASSERT_SAME(a_ready_low_only_when_full, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready)

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam int LIMIT = 600000;

    typedef struct {
        mmf_pkg::t_opcode op;
        logic [1:0]  row;
        logic [31:0] e [4];
        bit          chk;
        logic [31:0] want [4];
    } t_vec;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] c [4];
    } t_prod_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;   // row_index, elem0, elem1, elem2, elem3, zero pad
    logic         s_axis_tuser = 1'b0; // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;        // out_row, out_c0, out_c1, out_c2, out_c3, zero pad

    logic [31:0] b_store [16];
    t_prod_row   row_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          mode = 0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    matrix4x4_float_multiply u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] sticky_shr32(logic [31:0] v, int n);
        if (n <= 0) return v;
        if (n >= 32) return {31'd0, |v};
        return (v >> n) | {31'd0, |(v & ((32'h1 << n) - 1))};
    endfunction

    function automatic logic [31:0] sticky_shr64(logic [63:0] v, int n);
        logic [63:0] r;
        r = (v >> n) | {63'd0, |(v & ((64'h1 << n) - 1))};
        return r[31:0];
    endfunction

    function automatic logic [31:0] round_nearest(logic s, int e, logic [31:0] sig);
        logic [31:0] m;
        logic [31:0] bits;
        logic [6:0]  rb;
        if (e >= 255) return {s, 31'h7F80_0000};
        if (e <= 0) begin
            sig = sticky_shr32(sig, 1 - e);
            e = 0;
        end
        rb = sig[6:0];
        m = (sig + 32'h40) >> 7;
        if (rb == 7'h40) m[0] = 1'b0;
        if (e == 0) bits = m;
        else bits = (32'(e) << 23) + m - 32'h0080_0000;
        if (bits >= 32'h7F80_0000) bits = 32'h7F80_0000;
        return {s, bits[30:0]};
    endfunction

    function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
        logic        s;
        int          ea, eb, e;
        logic [31:0] ma, mb;
        logic [63:0] p;
        s = a[31] ^ b[31];
        ea = int'(a[30:23]);
        eb = int'(b[30:23]);
        ma = {9'd0, a[22:0]};
        mb = {9'd0, b[22:0]};
        if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return mmf_pkg::QNAN;
        if (a[30:0] == 31'h7F80_0000 || b[30:0] == 31'h7F80_0000) begin
            if (a[30:0] == 0 || b[30:0] == 0) return mmf_pkg::QNAN;
            return {s, 31'h7F80_0000};
        end
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        if (ea == 0) begin
            ea = 1;
            while (!ma[23]) begin ma = ma << 1; ea--; end
        end else ma[23] = 1'b1;
        if (eb == 0) begin
            eb = 1;
            while (!mb[23]) begin mb = mb << 1; eb--; end
        end else mb[23] = 1'b1;
        p = 64'(ma) * 64'(mb);
        e = ea + eb - 127;
        if (p[47]) return round_nearest(s, e + 1, sticky_shr64(p, 17));
        return round_nearest(s, e, sticky_shr64(p, 16));
    endfunction

    function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] t, ma, mb, r;
        logic        sa, sb, ts;
        int          ea, eb;
        sa = a[31];
        sb = b[31];
        if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return mmf_pkg::QNAN;
        if (a[30:0] == 31'h7F80_0000) begin
            if (b[30:0] == 31'h7F80_0000 && sa != sb) return mmf_pkg::QNAN;
            return a;
        end
        if (b[30:0] == 31'h7F80_0000) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {sa & sb, 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        if (a[30:0] < b[30:0]) begin
            t = a; a = b; b = t;
            ts = sa; sa = sb; sb = ts;
        end
        ea = int'(a[30:23]);
        eb = int'(b[30:23]);
        ma = {9'd0, a[22:0]};
        mb = {9'd0, b[22:0]};
        if (ea == 0) ea = 1; else ma[23] = 1'b1;
        if (eb == 0) eb = 1; else mb[23] = 1'b1;
        ma = ma << 7;
        mb = sticky_shr32(mb << 7, ea - eb);
        if (sa == sb) begin
            r = ma + mb;
            if (r[31]) begin r = sticky_shr32(r, 1); ea++; end
            return round_nearest(sa, ea, r);
        end
        r = ma - mb;
        if (r == 0) return 32'd0;
        while (r < 32'h4000_0000 && ea > 1) begin r = r << 1; ea--; end
        return round_nearest(sa, ea, r);
    endfunction

    // Update the B store or compute the product row for one accepted item.
    function automatic bit predict_row(t_vec v, output t_prod_row pr);
        logic [31:0] acc;
        if (v.op == mmf_pkg::OP_LOAD) begin
            for (int j = 0; j < 4; j++) b_store[{v.row, 2'(j)}] = v.e[j];
            return 1'b0;
        end
        pr.row = v.row;
        for (int j = 0; j < 4; j++) begin
            acc = sp_mul(v.e[0], b_store[4'(j)]);
            for (int i = 1; i < 4; i++) begin
                acc = sp_add(acc, sp_mul(v.e[i], b_store[{2'(i), 2'(j)}]));
            end
            pr.c[j] = acc;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
            32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h807F_FFFF, 32'h7F7F_FFFF};
        case ($urandom_range(0, 9))
            0: return specials[$urandom_range(0, 9)];
            1: return $urandom();
            2: return {1'($urandom()), 8'd0, 23'($urandom())};
            default: return {1'($urandom()), 8'($urandom_range(100, 154)), 23'($urandom())};
        endcase
    endfunction

    task automatic send(t_vec v);
        t_prod_row pr;
        int        gap_pct;
        gap_pct = (mode == 1) ? 75 : (mode == 3) ? 10 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= v.op;
        s_axis_tdata  <= {6'd0, v.e[3], v.e[2], v.e[1], v.e[0], v.row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_row(v, pr)) begin
            if (v.chk) begin
                for (int j = 0; j < 4; j++) pr.c[j] = v.want[j];
            end
            row_q.push_back(pr);
        end
    endtask

    // Receiver: long hold once when asked, otherwise random stalls by phase.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (mode == 2) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 75);
        end else if (mode == 3) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_prod_row want;
        logic [31:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_q.size() == 0) begin
                $error("product row with no item pending: %h", m_axis_tdata);
                errors++;
            end else begin
                want = row_q.pop_front();
                if (m_axis_tdata[1:0] !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, m_axis_tdata[1:0]);
                    errors++;
                end
                for (int j = 0; j < 4; j++) begin
                    got = m_axis_tdata[2 + 32 * j +: 32];
                    if (got !== want.c[j]) begin
                        $error("out_c%0d: expected %h, got %h", j, want.c[j], got);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_vec table_in [$];
        t_vec v;
        int   per_phase;
        // op, row, elements, checked, expected
        table_in = '{
            '{mmf_pkg::OP_LOAD, 2'd0, '{32'h3F80_0000, 0, 0, 0}, 0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_LOAD, 2'd1, '{0, 32'h3F80_0000, 0, 0}, 0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_LOAD, 2'd2, '{0, 0, 32'h3F80_0000, 0}, 0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_LOAD, 2'd3, '{0, 0, 0, 32'h3F80_0000}, 0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_MUL, 2'd0,
              '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000}, 1,
              '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000}},
            '{mmf_pkg::OP_MUL, 2'd3,
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1,
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}},
            '{mmf_pkg::OP_MUL, 2'd1, '{32'h7F80_0001, 0, 0, 0}, 1,
              '{mmf_pkg::QNAN, mmf_pkg::QNAN, mmf_pkg::QNAN, mmf_pkg::QNAN}},
            '{mmf_pkg::OP_MUL, 2'd2,
              '{32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000}, 1,
              '{32'h7F80_0000, mmf_pkg::QNAN, mmf_pkg::QNAN, mmf_pkg::QNAN}},
            '{mmf_pkg::OP_MUL, 2'd0,
              '{32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF}, 0,
              '{0, 0, 0, 0}},
            '{mmf_pkg::OP_MUL, 2'd3,
              '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
              '{mmf_pkg::QNAN, mmf_pkg::QNAN, mmf_pkg::QNAN, mmf_pkg::QNAN}},
            '{mmf_pkg::OP_LOAD, 2'd0,
              '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000},
              0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_MUL, 2'd1, '{32'h7F7F_FFFF, 0, 0, 0}, 1,
              '{32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000}},
            '{mmf_pkg::OP_MUL, 2'd2, '{32'h3F80_0000, 32'hC000_0000, 0, 0}, 0,
              '{0, 0, 0, 0}},
            '{mmf_pkg::OP_LOAD, 2'd3,
              '{32'h0000_0001, 32'h3F00_0000, 32'h8000_0001, 32'hFF80_0000},
              0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_MUL, 2'd3,
              '{32'h3F80_0000, 32'h0000_0000, 32'h4000_0000, 32'h3F00_0000}, 0,
              '{0, 0, 0, 0}},
            '{mmf_pkg::OP_LOAD, 2'd1,
              '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7F80_0000},
              0, '{0, 0, 0, 0}},
            '{mmf_pkg::OP_MUL, 2'd0,
              '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h0080_0000}, 0,
              '{0, 0, 0, 0}}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_in[k]) send(table_in[k]);

        per_phase = 490;
        for (int ph = 0; ph < 4; ph++) begin
            mode = ph;
            // fill the pipeline against a held-off receiver
            if (ph == 0) hold_go <= 1'b1;
            for (int n = 0; n < per_phase; n++) begin
                v.op = ($urandom_range(0, 3) == 0) ? mmf_pkg::OP_LOAD : mmf_pkg::OP_MUL;
                v.row = 2'($urandom_range(0, 3));
                for (int j = 0; j < 4; j++) v.e[j] = rand_float();
                v.chk = 1'b0;
                send(v);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (row_q.size() != 0) @(posedge i_clk);
        repeat (mmf_pkg::PIPE_LAT + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[matrix4x4_float_multiply.f]
+incdir+design
design/mmf_pkg.sv
design/mmf_fmul.sv
design/mmf_fadd.sv
design/mmf_column.sv
design/matrix4x4_float_multiply.sv
test/tb.sv
